// File: rtl/ipc_pkg.sv
package ipc_pkg;

  localparam int GainW = 16;
  localparam int DataW = 16;
  localparam int SumW  = 36;
  localparam int ProdW = 53;

  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [1:0] REG_DERIV_GAIN = 2'd2;

  localparam logic [GainW-1:0] PROP_GAIN_RESET  = 16'd256;
  localparam logic [GainW-1:0] INTEG_GAIN_RESET = 16'd0;
  localparam logic [GainW-1:0] DERIV_GAIN_RESET = 16'd0;

  localparam logic signed [DataW-1:0] DRIVE_MAX = 16'sd25600;
  localparam logic signed [DataW-1:0] DRIVE_MIN = -16'sd25600;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_MUL_D,
    ST_ADD,
    ST_MUL_P,
    ST_FINISH
  } ipc_state_t;

  typedef struct packed {
    logic load;
    logic mul_integ;
    logic mul_deriv;
    logic add_prod;
    logic mul_prop;
    logic finish;
  } ipc_cmd_t;

  typedef struct packed {
    logic zero_oldest;
    logic out_free;
  } ipc_status_t;

endpackage

// File: rtl/ipc_ctrl.sv
module ipc_ctrl
  import ipc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  ipc_status_t status,
  output ipc_cmd_t    cmd
);

  ipc_state_t state, state_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A new transaction may enter while the previous result is written out.
  assign in_stall = !((state == ST_IDLE) || (state == ST_FINISH && status.out_free));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = status.zero_oldest ? ST_FINISH : ST_MUL_I;
        end
      end
      ST_MUL_I: state_next = ST_MUL_D;
      ST_MUL_D: state_next = ST_ADD;
      ST_ADD:   state_next = ST_MUL_P;
      ST_MUL_P: state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) begin
          if (accept) begin
            state_next = status.zero_oldest ? ST_FINISH : ST_MUL_I;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    case (state)
      ST_MUL_I:  cmd.mul_integ = 1'b1;
      ST_MUL_D:  cmd.mul_deriv = 1'b1;
      ST_ADD:    cmd.add_prod  = 1'b1;
      ST_MUL_P:  cmd.mul_prop  = 1'b1;
      ST_FINISH: cmd.finish    = status.out_free;
      default:   cmd.finish    = 1'b0;
    endcase
  end

endmodule

// File: rtl/ipc_datapath.sv
module ipc_datapath
  import ipc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [GainW-1:0]        cfg_data,
  input  logic signed [DataW-1:0] error_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DataW-1:0] drive_value,
  input  ipc_cmd_t                cmd,
  output ipc_status_t             status
);

  logic [GainW-1:0]        prop_gain, integ_gain, deriv_gain;
  logic signed [DataW-1:0] hist0, hist1, hist2, accum;
  logic                    bypass;
  logic signed [SumW-1:0]  sum;
  logic signed [ProdW-1:0] prod;

  logic signed [16:0]      diff1;
  logic signed [17:0]      diff2;
  logic signed [16:0]      mul_a;
  logic signed [SumW-1:0]  mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [ProdW:0]   total;
  logic signed [37:0]      shifted;
  logic signed [DataW-1:0] clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= PROP_GAIN_RESET;
      integ_gain <= INTEG_GAIN_RESET;
      deriv_gain <= DERIV_GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PROP_GAIN:  prop_gain  <= cfg_data;
        REG_INTEG_GAIN: integ_gain <= cfg_data;
        REG_DERIV_GAIN: deriv_gain <= cfg_data;
        default:        prop_gain  <= prop_gain;
      endcase
    end
  end

  assign status.zero_oldest = (hist1 == '0);
  assign status.out_free    = !out_valid || !out_stall;

  assign diff1 = {hist0[15], hist0} - {hist1[15], hist1};
  assign diff2 = {{2{hist0[15]}}, hist0} - {hist1[15], hist1, 1'b0} + {{2{hist2[15]}}, hist2};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_integ) begin
      mul_a = {1'b0, integ_gain};
      mul_b = {{20{hist0[15]}}, hist0};
    end else if (cmd.mul_deriv) begin
      mul_a = {1'b0, deriv_gain};
      mul_b = {{18{diff2[17]}}, diff2};
    end else if (cmd.mul_prop) begin
      mul_a = {1'b0, prop_gain};
      mul_b = sum;
    end
  end

  assign mul_p = mul_a * mul_b;

  // Adding the accumulator at weight 2^16 together with the rounding half lets
  // one add produce accum + round(prod / 2^16).
  assign total   = {prod[ProdW-1], prod}
                 + {{22{accum[15]}}, accum, 16'h8000};
  assign shifted = total[ProdW:16];

  always_comb begin
    if (shifted > 38'(DRIVE_MAX)) begin
      clamped = DRIVE_MAX;
    end else if (shifted < 38'(DRIVE_MIN)) begin
      clamped = DRIVE_MIN;
    end else begin
      clamped = shifted[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist0  <= '0;
      hist1  <= '0;
      hist2  <= '0;
      accum  <= '0;
      bypass <= 1'b0;
    end else begin
      if (cmd.load) begin
        hist0  <= error_sample;
        hist1  <= hist0;
        hist2  <= hist1;
        bypass <= (hist1 == '0);
      end
      if (cmd.finish && !bypass) begin
        accum <= clamped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_integ) begin
      sum <= {{11{diff1[16]}}, diff1, 8'h00};
    end else if (cmd.mul_deriv || cmd.add_prod) begin
      sum <= sum + $signed(prod[SumW-1:0]);
    end
    if (cmd.mul_integ || cmd.mul_deriv || cmd.mul_prop) begin
      prod <= mul_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      drive_value <= bypass ? '0 : clamped;
    end
  end

endmodule

// File: rtl/incremental_pid_clamped.sv
// An accepted transaction runs ST_MUL_I, ST_MUL_D, ST_ADD and ST_MUL_P (skipped
// if the oldest history entry is zero); ST_FINISH registers the result when the
// output is free. The shared 17x36 multiplier runs the integral, derivative and
// proportional products in turn; new input enters only in ST_IDLE or ST_FINISH.
// Reset (rst, synchronous): history and running output cleared, gains to defaults.
module incremental_pid_clamped
  import ipc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [GainW-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [DataW-1:0] error_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DataW-1:0] drive_value
);

  ipc_cmd_t    cmd;
  ipc_status_t status;

  ipc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ipc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .error_sample (error_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive_value  (drive_value),
    .cmd          (cmd),
    .status       (status)
  );

`ifndef SYNTHESIS
  a_drive_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_value <= DRIVE_MAX && drive_value >= DRIVE_MIN))
    else $error("drive value outside clamp range");

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished transaction did not reach the output register");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mul_integ, cmd.mul_deriv, cmd.add_prod, cmd.mul_prop, cmd.finish}))
    else $error("more than one datapath step commanded");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_integ || cmd.mul_deriv || cmd.add_prod || cmd.mul_prop) |-> !cmd.load)
    else $error("transaction accepted while datapath busy");
`endif

endmodule
